### hw/rtl/eqhz_pkg.sv
// eqhz_pkg: shared types, constants and arithmetic helpers for the
// equatorial to horizontal transform pipeline. No dependencies.
package eqhz_pkg;

  localparam int SC_W = 34;  // Q1.30 sine/cosine datapath
  localparam int VW   = 36;  // vectoring datapath
  localparam int ZW   = 34;  // CORDIC angle accumulator
  localparam int MAX_STAGES = 40;

  typedef logic        [31:0]   ang_t;
  typedef logic signed [SC_W-1:0] sc_t;
  typedef logic signed [VW-1:0]   vec_t;
  typedef logic signed [ZW-1:0]   zang_t;

  typedef enum logic [3:0] {
    REG_LONGITUDE = 4'd0,
    REG_LATITUDE  = 4'd1
  } cfg_reg_t;

  localparam logic signed [VW-1:0] INV_GAIN = VW'(652032874);
  localparam logic signed [ZW-1:0] QUARTER  = ZW'(1073741824);
  localparam logic        [31:0]   HALF_TURN = 32'h8000_0000;

  // Side information that rides along the first vectoring unit.
  typedef struct packed {
    vec_t az;
    logic base;   // vector was flipped, add a half turn
    logic degen;  // both azimuth terms zero
  } vec1_sb_t;

  // Side information that rides along the second vectoring unit.
  typedef struct packed {
    ang_t azi;
    logic degen;
  } vec2_sb_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_lut(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Q1.30 product with floor rounding
  function automatic vec_t mul30(input vec_t a, input vec_t b);
    logic signed [2*VW-1:0] p;
    p = a * b;
    return p[30 +: VW];
  endfunction

endpackage

### hw/rtl/eqhz_rot_cordic.sv
// eqhz_rot_cordic: pipelined rotation CORDIC, binary angle in, sine and
// cosine (Q1.30) out. Uses eqhz_pkg.
module eqhz_rot_cordic #(
  parameter int STAGES = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  eqhz_pkg::ang_t in_ang,
  output logic           out_vld,
  output eqhz_pkg::sc_t  out_sin,
  output eqhz_pkg::sc_t  out_cos
);
  import eqhz_pkg::*;

  sc_t   x_r [0:STAGES];
  sc_t   y_r [0:STAGES];
  zang_t z_r [0:STAGES];
  logic  neg_r [0:STAGES];
  logic  vld_r [0:STAGES];
  logic  fold;
  ang_t  ang_f;

  // fold into [-1/4, 1/4) turn
  assign fold  = (in_ang[31:30] == 2'b01) || (in_ang[31:30] == 2'b10);
  assign ang_f = fold ? (in_ang ^ HALF_TURN) : in_ang;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    x_r[0]   <= SC_W'(652032874);
    y_r[0]   <= '0;
    z_r[0]   <= ZW'(signed'(ang_f));
    neg_r[0] <= fold;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [31:0] at;
    assign at = atan_lut(i);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      neg_r[i+1] <= neg_r[i];
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - signed'(ZW'(at));
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + signed'(ZW'(at));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld_r[STAGES];
    end
    out_sin <= neg_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
    out_cos <= neg_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
  end

endmodule

### hw/rtl/eqhz_prod.sv
// eqhz_prod: three-stage product network forming the azimuth terms and
// the altitude term from the sines and cosines. Uses eqhz_pkg.
module eqhz_prod (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  eqhz_pkg::sc_t      sh,
  input  eqhz_pkg::sc_t      ch,
  input  eqhz_pkg::sc_t      sl,
  input  eqhz_pkg::sc_t      cl,
  input  eqhz_pkg::sc_t      sd,
  input  eqhz_pkg::sc_t      cd,
  output logic               out_vld,
  output eqhz_pkg::vec_t     out_x,
  output eqhz_pkg::vec_t     out_y,
  output eqhz_pkg::vec1_sb_t out_sb
);
  import eqhz_pkg::*;

  vec_t p1_r, p2_r, ay_r, p3_r, p4_r, cd_r, ch_r;
  vec_t q1_r, q2_r, p2b_r, ayb_r, p3b_r;
  logic v1_r, v2_r;
  vec_t ax, az;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1_r    <= in_vld;
      v2_r    <= v1_r;
      out_vld <= v2_r;
    end
    p1_r <= mul30(VW'(ch), VW'(sl));
    p2_r <= mul30(VW'(sd), VW'(cl));
    ay_r <= mul30(VW'(sh), VW'(cd));
    p3_r <= mul30(VW'(sl), VW'(sd));
    p4_r <= mul30(VW'(cl), VW'(cd));
    cd_r <= VW'(cd);
    ch_r <= VW'(ch);
    q1_r  <= mul30(p1_r, cd_r);
    q2_r  <= mul30(p4_r, ch_r);
    p2b_r <= p2_r;
    ayb_r <= ay_r;
    p3b_r <= p3_r;
  end

  assign ax = q1_r - p2b_r;
  assign az = p3b_r + q2_r;

  // left half plane: flip the vector, a half turn goes on later
  always_ff @(posedge clk) begin
    out_x        <= ax[VW-1] ? -ax : ax;
    out_y        <= ax[VW-1] ? -ayb_r : ayb_r;
    out_sb.az    <= az;
    out_sb.base  <= ax[VW-1];
    out_sb.degen <= (ax == '0) && (ayb_r == '0);
  end

endmodule

### hw/rtl/eqhz_vec_cordic.sv
// eqhz_vec_cordic: pipelined vectoring CORDIC, (x, y) with x >= 0 in,
// angle and gain-scaled magnitude out, side bits carried. Uses eqhz_pkg.
module eqhz_vec_cordic #(
  parameter int STAGES = 32,
  parameter int SB_W   = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  eqhz_pkg::vec_t  in_x,
  input  eqhz_pkg::vec_t  in_y,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_vld,
  output eqhz_pkg::vec_t  out_mag,
  output eqhz_pkg::zang_t out_ang,
  output logic [SB_W-1:0] out_sb
);
  import eqhz_pkg::*;

  vec_t            x_s [0:STAGES];
  vec_t            y_s [0:STAGES];
  zang_t           z_s [0:STAGES];
  logic            v_s [0:STAGES];
  logic [SB_W-1:0] sb_s [0:STAGES];

  assign x_s[0]  = in_x;
  assign y_s[0]  = in_y;
  assign z_s[0]  = '0;
  assign v_s[0]  = in_vld;
  assign sb_s[0] = in_sb;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [31:0] at;
    assign at = atan_lut(i);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[i+1] <= 1'b0;
      end else begin
        v_s[i+1] <= v_s[i];
      end
      sb_s[i+1] <= sb_s[i];
      if (!y_s[i][VW-1]) begin
        x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
        y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
        z_s[i+1] <= z_s[i] + signed'(ZW'(at));
      end else begin
        x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
        y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
        z_s[i+1] <= z_s[i] - signed'(ZW'(at));
      end
    end
  end

  assign out_vld = v_s[STAGES];
  assign out_mag = x_s[STAGES];
  assign out_ang = z_s[STAGES];
  assign out_sb  = sb_s[STAGES];

endmodule

### hw/rtl/equatorial_to_horizontal_top.sv
// equatorial_to_horizontal_top: top level of the coordinate transform.
// Depends on eqhz_pkg, eqhz_rot_cordic, eqhz_prod and eqhz_vec_cordic.
//
// Converts right ascension, declination and sidereal angle into altitude
// and azimuth (from south) for the observer set in the two registers. The
// block is fully pipelined: busy stays low, an item may be started every
// cycle, and each result appears on out_valid after passing the input
// register, the three chained CORDIC pipelines (sin/cos, azimuth
// vectoring, altitude vectoring), the product and gain-correction stages
// and the output register. Results cannot be held off.
// Registers may only be changed while no item is in flight.
module equatorial_to_horizontal_top #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_right_ascension,
  input  logic signed [31:0] in_declination,
  input  logic [31:0] in_sidereal_angle,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic signed [31:0] out_altitude,
  output logic [31:0] out_azimuth
);
  import eqhz_pkg::*;

  ang_t lon_r, lat_r;
  ang_t h_r, latp_r, dec_r;
  logic e_vld_r;
  logic acc;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_r <= '0;
      lat_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONGITUDE: lon_r <= cfg_data;
        REG_LATITUDE:  lat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // hour angle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= acc;
    end
    h_r    <= in_sidereal_angle - lon_r - in_right_ascension;
    latp_r <= lat_r;
    dec_r  <= ang_t'(in_declination);
  end

  logic rv_h, rv_l, rv_d;
  sc_t  sh, ch, sl, cl, sd, cd;

  eqhz_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_h (
    .clk, .rst_n, .in_vld(e_vld_r), .in_ang(h_r),
    .out_vld(rv_h), .out_sin(sh), .out_cos(ch));
  eqhz_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_l (
    .clk, .rst_n, .in_vld(e_vld_r), .in_ang(latp_r),
    .out_vld(rv_l), .out_sin(sl), .out_cos(cl));
  eqhz_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_d (
    .clk, .rst_n, .in_vld(e_vld_r), .in_ang(dec_r),
    .out_vld(rv_d), .out_sin(sd), .out_cos(cd));

  logic     p_vld;
  vec_t     p_x, p_y;
  vec1_sb_t p_sb;

  eqhz_prod u_prod (
    .clk, .rst_n, .in_vld(rv_h && rv_l && rv_d),
    .sh, .ch, .sl, .cl, .sd, .cd,
    .out_vld(p_vld), .out_x(p_x), .out_y(p_y), .out_sb(p_sb));

  logic     v1_vld;
  vec_t     v1_mag;
  zang_t    v1_ang;
  vec1_sb_t v1_sb;

  eqhz_vec_cordic #(.STAGES(CORDIC_STAGES), .SB_W($bits(vec1_sb_t))) u_vec_az (
    .clk, .rst_n, .in_vld(p_vld), .in_x(p_x), .in_y(p_y), .in_sb(p_sb),
    .out_vld(v1_vld), .out_mag(v1_mag), .out_ang(v1_ang), .out_sb(v1_sb));

  // gain correction of the horizontal magnitude, azimuth quadrant fix
  logic g_vld_r;
  vec_t r_r, az_r;
  ang_t azi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= v1_vld;
    end
    r_r   <= v1_sb.degen ? '0 : mul30(v1_mag, INV_GAIN);
    azi_r <= v1_sb.degen ? '0 :
             (v1_ang[31:0] + (v1_sb.base ? HALF_TURN : 32'h0));
    az_r  <= v1_sb.az;
  end

  vec2_sb_t g_sb, v2_sb;
  logic     v2_vld;
  vec_t     v2_mag;
  zang_t    v2_ang;

  assign g_sb.azi   = azi_r;
  assign g_sb.degen = (r_r == '0) && (az_r == '0);

  eqhz_vec_cordic #(.STAGES(CORDIC_STAGES), .SB_W($bits(vec2_sb_t))) u_vec_alt (
    .clk, .rst_n, .in_vld(g_vld_r), .in_x(r_r), .in_y(az_r), .in_sb(g_sb),
    .out_vld(v2_vld), .out_mag(v2_mag), .out_ang(v2_ang), .out_sb(v2_sb));

  zang_t alt;

  always_comb begin
    if (v2_sb.degen) begin
      alt = '0;
    end else if (v2_ang > QUARTER) begin
      alt = QUARTER;
    end else if (v2_ang < -QUARTER) begin
      alt = -QUARTER;
    end else begin
      alt = v2_ang;
    end
  end

  // magnitude of the altitude vector is not needed
  logic mag_unused;
  assign mag_unused = ^v2_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2_vld && (mag_unused || !mag_unused);
    end
    out_altitude <= alt[31:0];
    out_azimuth  <= v2_sb.azi;
  end

endmodule

### hw/rtl/eqhz_checker.sv
// eqhz_port_props: port-level assertions for equatorial_to_horizontal_top,
// bound to the top level below. Depends on the top level's ports only.
module eqhz_port_props #(
  parameter int CORDIC_STAGES = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_right_ascension,
  input logic signed [31:0] in_declination,
  input logic [31:0] in_sidereal_angle,
  input logic        cfg_we,
  input logic [3:0]  cfg_index,
  input logic [31:0] cfg_data,
  input logic        out_valid,
  input logic signed [31:0] out_altitude,
  input logic [31:0] out_azimuth
);
  localparam int LAT = 3 * CORDIC_STAGES + 8;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching start");

  a_alt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_altitude <= 32'sd1073741824 &&
                   out_altitude >= -32'sd1073741824))
    else $error("altitude beyond a quarter turn");

  a_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("pipeline refused an item");

endmodule

bind equatorial_to_horizontal_top eqhz_port_props #(.CORDIC_STAGES(CORDIC_STAGES)) u_chk (.*);
